[hdl/hwh_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// Shared widths, stage counts, register indexes and hue sector codes for the
// hue wheel HSV-to-RGB core and its checker. No dependencies.

package hwh_pkg;

    localparam int IDX_W  = 16;
    localparam int CNT_W  = 16;
    localparam int FRAC_W = 16;
    localparam int CH_W   = 8;
    localparam int SIX_W  = 19;
    localparam int PROD_W = 24;
    localparam int NUM_W  = 32;
    localparam int SEC_W  = 3;

    localparam int MOD_STAGES  = IDX_W;
    localparam int SEC_STAGES  = 4;
    localparam int FRAC_STAGES = FRAC_W;
    localparam int CH_STAGES   = 5;
    localparam int PIPE_DEPTH  = MOD_STAGES + SEC_STAGES + FRAC_STAGES + CH_STAGES;
    localparam int DEPTH_W     = $clog2(PIPE_DEPTH + 1);

    localparam int MOD_BASE  = 0;
    localparam int SEC_BASE  = MOD_BASE + MOD_STAGES;
    localparam int FRAC_BASE = SEC_BASE + SEC_STAGES;
    localparam int CH_BASE   = FRAC_BASE + FRAC_STAGES;

    // 255 * 65536: full scale of the fractional channel terms
    localparam logic [PROD_W-1:0] FULL_SCALE = PROD_W'(24'd16711680);
    localparam logic [FRAC_W:0]   FRAC_ONE   = {1'b1, {FRAC_W{1'b0}}};

    localparam int REG_ADDR_W = 2;
    localparam int REG_DATA_W = 16;
    localparam logic [REG_ADDR_W-1:0] REG_COLOR_COUNT = 2'd0;
    localparam logic [REG_ADDR_W-1:0] REG_SATURATION  = 2'd1;
    localparam logic [REG_ADDR_W-1:0] REG_BRIGHTNESS  = 2'd2;

    localparam logic [SEC_W-1:0] SEC_RED_YEL = 3'd0;
    localparam logic [SEC_W-1:0] SEC_YEL_GRN = 3'd1;
    localparam logic [SEC_W-1:0] SEC_GRN_CYN = 3'd2;
    localparam logic [SEC_W-1:0] SEC_CYN_BLU = 3'd3;
    localparam logic [SEC_W-1:0] SEC_BLU_MAG = 3'd4;
    localparam logic [SEC_W-1:0] SEC_MAG_RED = 3'd5;

    // floor(y / 255) for y <= 65025, as ((y + 1) * 257) >> 16
    function automatic logic [CH_W-1:0] div255(input logic [15:0] y);
        logic [16:0] y1;
        logic [25:0] prod;
        y1   = {1'b0, y} + 17'd1;
        prod = {1'b0, y1, 8'b0} + {9'b0, y1};
        return prod[23:16];
    endfunction

endpackage

`default_nettype wire

[hdl/hue_wheel_hsv_to_rgb_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// Hue wheel HSV-to-RGB core: index -> RGB on an evenly divided hue wheel.
// Depends on hwh_pkg.
//
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+-------------------------------------
//  s_      | in  | s_tvalid/s_tready | s_tdata[15:0] color_index
//  m_      | out | m_tvalid/m_tready | m_tdata red[7:0] green[15:8] blue[23:16]
//  cfg_    | in  | cfg_we            | cfg_addr index, cfg_wdata value
//
// One transaction per cycle sustained while the output is not stalled; stages:
// 16 remainder, 4 sector and 16 fraction quotient steps and 5 channel stages.
// Every stage holds its own valid bit; a stage advances when empty or when the
// stage after it advances, so bubbles close up while the output is stalled.
// Reset clears valid bits and loads count 16, saturation and brightness 255.

module hue_wheel_hsv_to_rgb_core
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [15:0] s_tdata,     // [15:0] color_index
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [23:0] m_tdata,     // [7:0] red, [15:8] green, [23:16] blue
    input  wire logic        cfg_we,
    input  wire logic [hwh_pkg::REG_ADDR_W-1:0] cfg_addr,
    input  wire logic [hwh_pkg::REG_DATA_W-1:0] cfg_wdata
);

    localparam int N = hwh_pkg::PIPE_DEPTH;

    logic [hwh_pkg::CNT_W-1:0] cnt_reg;
    logic [hwh_pkg::CH_W-1:0]  sat_reg;
    logic [hwh_pkg::CH_W-1:0]  val_reg;

    logic vld_reg [N];
    logic vin     [N];
    logic en      [N+1];

    logic [hwh_pkg::CNT_W-1:0] mod_rem_reg [hwh_pkg::MOD_STAGES];
    logic [hwh_pkg::IDX_W-1:0] mod_div_reg [hwh_pkg::MOD_STAGES];

    logic [hwh_pkg::SIX_W-1:0] sec_six_reg [hwh_pkg::SEC_STAGES];
    logic [hwh_pkg::SEC_W-1:0] sec_bits_reg [hwh_pkg::SEC_STAGES];

    logic [hwh_pkg::CNT_W-1:0]  frac_rem_reg [hwh_pkg::FRAC_STAGES];
    logic [hwh_pkg::FRAC_W-1:0] frac_quo_reg [hwh_pkg::FRAC_STAGES];
    logic [hwh_pkg::SEC_W-1:0]  frac_sec_reg [hwh_pkg::FRAC_STAGES];

    logic [hwh_pkg::PROD_W-1:0] sfq_reg, sft_reg, dq_reg, dt_reg;
    logic [15:0]                pv0_reg, pv1_reg, pv2_reg;
    logic [hwh_pkg::NUM_W-1:0]  nq_reg, nt_reg;
    logic [hwh_pkg::CH_W-1:0]   q_reg, t_reg, p_reg;
    logic [hwh_pkg::SEC_W-1:0]  c0_sec_reg, c1_sec_reg, c2_sec_reg, c3_sec_reg;
    logic [hwh_pkg::CH_W-1:0]   red_reg, green_reg, blue_reg;
    logic [hwh_pkg::CH_W-1:0]   red_next, green_next, blue_next;

    // configuration; a zero count behaves as one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 16'd16;
            sat_reg <= 8'd255;
            val_reg <= 8'd255;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                hwh_pkg::REG_COLOR_COUNT:
                    cnt_reg <= (cfg_wdata == '0) ? 16'd1 : cfg_wdata[hwh_pkg::CNT_W-1:0];
                hwh_pkg::REG_SATURATION:
                    sat_reg <= cfg_wdata[hwh_pkg::CH_W-1:0];
                hwh_pkg::REG_BRIGHTNESS:
                    val_reg <= cfg_wdata[hwh_pkg::CH_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // valid chain and stage enables
    assign en[N] = m_tready;

    generate
        for (genvar i = 0; i < N; i++)
        begin : g_vld
            if (i == 0)
            begin : g_first
                assign vin[i] = s_tvalid;
            end
            else
            begin : g_rest
                assign vin[i] = vld_reg[i-1];
            end

            assign en[i] = !vld_reg[i] || en[i+1];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[i] <= 1'b0;
                else if (en[i])
                    vld_reg[i] <= vin[i];
            end
        end
    endgenerate

    assign s_tready = en[0];
    assign m_tvalid = vld_reg[N-1];

    // index mod count, one restoring step per stage
    generate
        for (genvar k = 0; k < hwh_pkg::MOD_STAGES; k++)
        begin : g_mod
            logic [hwh_pkg::CNT_W-1:0] r_in;
            logic [hwh_pkg::IDX_W-1:0] d_in;
            logic [hwh_pkg::CNT_W:0]   t;
            logic                      ge;
            logic [hwh_pkg::CNT_W-1:0] rem_next;

            if (k == 0)
            begin : g_src_in
                assign r_in = '0;
                assign d_in = s_tdata;
            end
            else
            begin : g_src_reg
                assign r_in = mod_rem_reg[k-1];
                assign d_in = mod_div_reg[k-1];
            end

            assign t        = {r_in, d_in[hwh_pkg::IDX_W-1]};
            assign ge       = t >= {1'b0, cnt_reg};
            assign rem_next = ge ? hwh_pkg::CNT_W'(t - {1'b0, cnt_reg})
                                 : t[hwh_pkg::CNT_W-1:0];

            always_ff @(posedge clk)
            begin
                if (en[hwh_pkg::MOD_BASE + k])
                begin
                    mod_rem_reg[k] <= rem_next;
                    mod_div_reg[k] <= {d_in[hwh_pkg::IDX_W-2:0], 1'b0};
                end
            end
        end
    endgenerate

    // 6 * remainder, then sector bits 2, 1, 0 by compare and subtract
    always_ff @(posedge clk)
    begin
        if (en[hwh_pkg::SEC_BASE])
        begin
            sec_six_reg[0]  <= {1'b0, mod_rem_reg[hwh_pkg::MOD_STAGES-1], 2'b0}
                             + {2'b0, mod_rem_reg[hwh_pkg::MOD_STAGES-1], 1'b0};
            sec_bits_reg[0] <= '0;
        end
    end

    generate
        for (genvar j = 1; j < hwh_pkg::SEC_STAGES; j++)
        begin : g_sec
            localparam int B = hwh_pkg::SEC_STAGES - 1 - j;
            logic [hwh_pkg::SIX_W-1:0] lim;
            logic                      ge;
            logic [hwh_pkg::SEC_W-1:0] bits_next;

            assign lim = {3'b0, cnt_reg} << B;
            assign ge  = sec_six_reg[j-1] >= lim;

            always_comb
            begin
                bits_next    = sec_bits_reg[j-1];
                bits_next[B] = ge;
            end

            always_ff @(posedge clk)
            begin
                if (en[hwh_pkg::SEC_BASE + j])
                begin
                    sec_six_reg[j]  <= ge ? sec_six_reg[j-1] - lim : sec_six_reg[j-1];
                    sec_bits_reg[j] <= bits_next;
                end
            end
        end
    endgenerate

    // frac = (six mod count) * 65536 / count, one quotient bit per stage
    generate
        for (genvar k = 0; k < hwh_pkg::FRAC_STAGES; k++)
        begin : g_frac
            logic [hwh_pkg::CNT_W-1:0]  r_in;
            logic [hwh_pkg::FRAC_W-1:0] q_in;
            logic [hwh_pkg::SEC_W-1:0]  s_in;
            logic [hwh_pkg::CNT_W:0]    t;
            logic                       ge;

            if (k == 0)
            begin : g_src_sec
                assign r_in = sec_six_reg[hwh_pkg::SEC_STAGES-1][hwh_pkg::CNT_W-1:0];
                assign q_in = '0;
                assign s_in = sec_bits_reg[hwh_pkg::SEC_STAGES-1];
            end
            else
            begin : g_src_reg
                assign r_in = frac_rem_reg[k-1];
                assign q_in = frac_quo_reg[k-1];
                assign s_in = frac_sec_reg[k-1];
            end

            assign t  = {r_in, 1'b0};
            assign ge = t >= {1'b0, cnt_reg};

            always_ff @(posedge clk)
            begin
                if (en[hwh_pkg::FRAC_BASE + k])
                begin
                    frac_rem_reg[k] <= ge ? hwh_pkg::CNT_W'(t - {1'b0, cnt_reg})
                                          : t[hwh_pkg::CNT_W-1:0];
                    frac_quo_reg[k] <= {q_in[hwh_pkg::FRAC_W-2:0], ge};
                    frac_sec_reg[k] <= s_in;
                end
            end
        end
    endgenerate

    // channel terms
    always_ff @(posedge clk)
    begin
        if (en[hwh_pkg::CH_BASE])
        begin
            sfq_reg    <= hwh_pkg::PROD_W'(sat_reg)
                        * hwh_pkg::PROD_W'(frac_quo_reg[hwh_pkg::FRAC_STAGES-1]);
            sft_reg    <= hwh_pkg::PROD_W'(sat_reg)
                        * hwh_pkg::PROD_W'(hwh_pkg::FRAC_ONE
                          - {1'b0, frac_quo_reg[hwh_pkg::FRAC_STAGES-1]});
            pv0_reg    <= 16'(val_reg) * 16'(8'd255 - sat_reg);
            c0_sec_reg <= frac_sec_reg[hwh_pkg::FRAC_STAGES-1];
        end
        if (en[hwh_pkg::CH_BASE + 1])
        begin
            dq_reg     <= hwh_pkg::FULL_SCALE - sfq_reg;
            dt_reg     <= hwh_pkg::FULL_SCALE - sft_reg;
            pv1_reg    <= pv0_reg;
            c1_sec_reg <= c0_sec_reg;
        end
        if (en[hwh_pkg::CH_BASE + 2])
        begin
            nq_reg     <= hwh_pkg::NUM_W'(val_reg) * hwh_pkg::NUM_W'(dq_reg);
            nt_reg     <= hwh_pkg::NUM_W'(val_reg) * hwh_pkg::NUM_W'(dt_reg);
            pv2_reg    <= pv1_reg;
            c2_sec_reg <= c1_sec_reg;
        end
        if (en[hwh_pkg::CH_BASE + 3])
        begin
            q_reg      <= hwh_pkg::div255(nq_reg[31:16]);
            t_reg      <= hwh_pkg::div255(nt_reg[31:16]);
            p_reg      <= hwh_pkg::div255(pv2_reg);
            c3_sec_reg <= c2_sec_reg;
        end
        if (en[hwh_pkg::CH_BASE + 4])
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    always_comb
    begin
        unique case (c3_sec_reg)
            hwh_pkg::SEC_RED_YEL:
            begin
                red_next = val_reg; green_next = t_reg; blue_next = p_reg;
            end
            hwh_pkg::SEC_YEL_GRN:
            begin
                red_next = q_reg; green_next = val_reg; blue_next = p_reg;
            end
            hwh_pkg::SEC_GRN_CYN:
            begin
                red_next = p_reg; green_next = val_reg; blue_next = t_reg;
            end
            hwh_pkg::SEC_CYN_BLU:
            begin
                red_next = p_reg; green_next = q_reg; blue_next = val_reg;
            end
            hwh_pkg::SEC_BLU_MAG:
            begin
                red_next = t_reg; green_next = p_reg; blue_next = val_reg;
            end
            hwh_pkg::SEC_MAG_RED:
            begin
                red_next = val_reg; green_next = p_reg; blue_next = q_reg;
            end
            default:
            begin
                red_next = val_reg; green_next = p_reg; blue_next = q_reg;
            end
        endcase
    end

    assign m_tdata = {blue_reg, green_reg, red_reg};

endmodule

`default_nettype wire

[hdl/hwh_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// Port-level checker for the hue wheel HSV-to-RGB core, bound to the top level.
// Depends on hwh_pkg and hue_wheel_hsv_to_rgb_core.

module hwh_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata
);

    logic [hwh_pkg::DEPTH_W-1:0] pend_reg;
    logic [hwh_pkg::DEPTH_W-1:0] pend_next;
    logic                        s_xfer;
    logic                        m_xfer;

    assign s_xfer = s_tvalid && s_tready;
    assign m_xfer = m_tvalid && m_tready;

    always_comb
    begin
        pend_next = pend_reg;
        if (s_xfer && !m_xfer)
            pend_next = pend_reg + 1'b1;
        else if (!s_xfer && m_xfer)
            pend_next = pend_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else
            pend_reg <= pend_next;
    end

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // a result only for a transaction taken in
    a_out_owed: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> pend_reg != '0)
        else $error("result without input");

    // in flight never beyond the stage count
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= hwh_pkg::DEPTH_W'(hwh_pkg::PIPE_DEPTH))
        else $error("more items in flight than stages");

    // input back-pressure only from a blocked output
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled while output free");

    // a full pipeline with the output not ready stalls the input
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg == hwh_pkg::DEPTH_W'(hwh_pkg::PIPE_DEPTH) && !m_tready |-> !s_tready)
        else $error("input taken into a full pipeline");

endmodule

bind hue_wheel_hsv_to_rgb_core hwh_checker u_hwh_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

[tb/tb_hue_wheel_hsv_to_rgb_core.sv]
`timescale 1ns / 1ps
// Self-checking testbench for hue_wheel_hsv_to_rgb_core: offers colour indexes
// over a series of wheel settings and compares every RGB transaction with an
// in-bench predictor. Depends on hwh_pkg and the core.

module tb_hue_wheel_hsv_to_rgb_core;

    localparam int PHASES      = 11;
    localparam int PHASE_ITEMS = 50;
    localparam int HOLD_CYCLES = 150;
    localparam int IDLE_LIMIT  = 2000;
    localparam int SETTLE      = hwh_pkg::PIPE_DEPTH + 10;

    typedef struct packed
    {
        logic [hwh_pkg::IDX_W-1:0] idx;
        logic [hwh_pkg::CH_W-1:0]  blue;
        logic [hwh_pkg::CH_W-1:0]  green;
        logic [hwh_pkg::CH_W-1:0]  red;
    } colour_due_t;

    class colour_tracker_t;
        logic [hwh_pkg::CNT_W-1:0] count;
        logic [hwh_pkg::CH_W-1:0]  sat;
        logic [hwh_pkg::CH_W-1:0]  val;
        colour_due_t               colours_due[$];
        int                        errors;
        int                        checked;

        function new();
            count   = 16'd16;
            sat     = 8'd255;
            val     = 8'd255;
            errors  = 0;
            checked = 0;
        endfunction

        function void set_reg(logic [hwh_pkg::REG_ADDR_W-1:0] addr,
                              logic [hwh_pkg::REG_DATA_W-1:0] data);
            case (addr)
                hwh_pkg::REG_COLOR_COUNT: count = data[hwh_pkg::CNT_W-1:0];
                hwh_pkg::REG_SATURATION:  sat   = data[hwh_pkg::CH_W-1:0];
                hwh_pkg::REG_BRIGHTNESS:  val   = data[hwh_pkg::CH_W-1:0];
                default: ;
            endcase
        endfunction

        // six-sector HSV to RGB at hue idx/count of a turn, channels truncated
        function colour_due_t wheel_colour(logic [hwh_pkg::IDX_W-1:0] idx);
            longint unsigned           span, pos, six, frac, v, s, p, q, t, scale;
            logic [hwh_pkg::SEC_W-1:0] sec;
            logic [hwh_pkg::CH_W-1:0]  v8, p8, q8, t8;
            colour_due_t               c;
            scale = 64'd255 * 64'd65536;
            span  = (count == '0) ? 64'd1 : 64'(count);
            pos   = 64'(idx) % span;
            six   = 64'd6 * pos;
            sec   = hwh_pkg::SEC_W'(six / span);
            frac  = ((six % span) * 64'd65536) / span;
            v     = 64'(val);
            s     = 64'(sat);
            p     = v * (64'd255 - s) / 64'd255;
            q     = v * (scale - s * frac) / scale;
            t     = v * (scale - s * (64'd65536 - frac)) / scale;
            v8    = hwh_pkg::CH_W'(v);
            p8    = hwh_pkg::CH_W'(p);
            q8    = hwh_pkg::CH_W'(q);
            t8    = hwh_pkg::CH_W'(t);
            c.idx = idx;
            case (sec)
                hwh_pkg::SEC_RED_YEL:
                begin
                    c.red = v8; c.green = t8; c.blue = p8;
                end
                hwh_pkg::SEC_YEL_GRN:
                begin
                    c.red = q8; c.green = v8; c.blue = p8;
                end
                hwh_pkg::SEC_GRN_CYN:
                begin
                    c.red = p8; c.green = v8; c.blue = t8;
                end
                hwh_pkg::SEC_CYN_BLU:
                begin
                    c.red = p8; c.green = q8; c.blue = v8;
                end
                hwh_pkg::SEC_BLU_MAG:
                begin
                    c.red = t8; c.green = p8; c.blue = v8;
                end
                default:
                begin
                    c.red = v8; c.green = p8; c.blue = q8;
                end
            endcase
            return c;
        endfunction

        function void note_index(logic [hwh_pkg::IDX_W-1:0] idx);
            colours_due.push_back(wheel_colour(idx));
        endfunction

        function void check_colour(logic [23:0] got);
            colour_due_t exp;
            if (colours_due.size() == 0)
            begin
                if (errors < 10)
                    $display("%0t: unexpected result %h", $realtime, got);
                errors++;
                return;
            end
            exp = colours_due.pop_front();
            checked++;
            if (got[7:0] !== exp.red || got[15:8] !== exp.green || got[23:16] !== exp.blue)
            begin
                if (errors < 10)
                    $display("%0t: index %0d rgb exp %0d/%0d/%0d got %0d/%0d/%0d",
                             $realtime, exp.idx, exp.red, exp.green, exp.blue,
                             got[7:0], got[15:8], got[23:16]);
                errors++;
            end
        endfunction

        function void close_out();
            if (colours_due.size() != 0)
            begin
                $display("%0d results never arrived", colours_due.size());
                errors += colours_due.size();
            end
        endfunction
    endclass

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [15:0]                    s_tdata   = '0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [23:0]                    m_tdata;
    logic                           cfg_we    = 1'b0;
    logic [hwh_pkg::REG_ADDR_W-1:0] cfg_addr  = hwh_pkg::REG_COLOR_COUNT;
    logic [hwh_pkg::REG_DATA_W-1:0] cfg_wdata = '0;

    colour_tracker_t board = new();
    bit              steady   = 1'b0;
    bit              hold_due = 1'b0;
    int              sent     = 0;
    int              quiet_cycles = 0;

    hue_wheel_hsv_to_rgb_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #4 clk = ~clk;

    task automatic offer_index(input logic [hwh_pkg::IDX_W-1:0] idx);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= idx;
        do @(posedge clk); while (!s_tready);
        board.note_index(idx);
        sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (board.colours_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic load_wheel(input logic [hwh_pkg::CNT_W-1:0] cnt,
                              input logic [hwh_pkg::CH_W-1:0]  sat,
                              input logic [hwh_pkg::CH_W-1:0]  val);
        cfg_we    <= 1'b1;
        cfg_addr  <= hwh_pkg::REG_COLOR_COUNT;
        cfg_wdata <= hwh_pkg::REG_DATA_W'(cnt);
        @(posedge clk);
        cfg_addr  <= hwh_pkg::REG_SATURATION;
        cfg_wdata <= hwh_pkg::REG_DATA_W'(sat);
        @(posedge clk);
        cfg_addr  <= hwh_pkg::REG_BRIGHTNESS;
        cfg_wdata <= hwh_pkg::REG_DATA_W'(val);
        @(posedge clk);
        cfg_we    <= 1'b0;
        board.set_reg(hwh_pkg::REG_COLOR_COUNT, hwh_pkg::REG_DATA_W'(cnt));
        board.set_reg(hwh_pkg::REG_SATURATION, hwh_pkg::REG_DATA_W'(sat));
        board.set_reg(hwh_pkg::REG_BRIGHTNESS, hwh_pkg::REG_DATA_W'(val));
    endtask

    // receiver: random back-pressure, one long hold-off on request
    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 3);
            if (hold_due)
            begin
                stall    = HOLD_CYCLES;
                hold_due = 1'b0;
            end
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            board.check_colour(m_tdata);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("tb_hue_wheel_hsv_to_rgb_core: errors");
            $finish;
        end
    end

    initial
    begin
        logic [hwh_pkg::CNT_W-1:0] cnt;
        logic [hwh_pkg::CH_W-1:0]  sat;
        logic [hwh_pkg::CH_W-1:0]  val;
        logic [hwh_pkg::IDX_W-1:0] idx;
        int                        span;
        int                        k;
        int                        p;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset wheel of 16: every sector, wrap past the count, index extremes
        for (k = 0; k < 18; k++)
            offer_index(hwh_pkg::IDX_W'(k));
        offer_index(16'hFFFF);
        offer_index(16'h8000);
        offer_index(16'hAAAA);
        offer_index(16'h5555);
        offer_index(16'h00FF);
        drain();

        for (p = 0; p < PHASES; p++)
        begin
            case (p)
                0:
                begin
                    cnt = 16'd0; sat = 8'd255; val = 8'd255; // zero count
                end
                1:
                begin
                    cnt = 16'd1; sat = 8'd128; val = 8'd200;
                end
                2:
                begin
                    cnt = 16'hFFFF; sat = 8'd255; val = 8'd255;
                end
                3:
                begin
                    cnt = 16'd6; sat = 8'd0; val = 8'd255;
                end
                4:
                begin
                    cnt = 16'd7; sat = 8'd255; val = 8'd0;
                end
                5:
                begin
                    cnt = 16'd360; sat = 8'd100; val = 8'd180;
                end
                6:
                begin
                    cnt = 16'hFFFF; sat = 8'd1; val = 8'd254;
                end
                default:
                begin
                    cnt = $urandom_range(0, 1)
                        ? hwh_pkg::CNT_W'($urandom_range(1, 64))
                        : hwh_pkg::CNT_W'($urandom_range(1, 65535));
                    sat = hwh_pkg::CH_W'($urandom_range(0, 255));
                    val = hwh_pkg::CH_W'($urandom_range(0, 255));
                end
            endcase
            steady = (p % 4 == 3);
            load_wheel(cnt, sat, val);
            span = (cnt == '0) ? 1 : int'(cnt);
            if (p == 3)
                hold_due = 1'b1;
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                if (p == 5 && k == PHASE_ITEMS / 2)
                    drain();
                idx = $urandom_range(0, 1)
                    ? hwh_pkg::IDX_W'($urandom_range(0, span - 1))
                    : hwh_pkg::IDX_W'($urandom);
                offer_index(idx);
            end
            drain();
        end

        steady = 1'b0;
        repeat (SETTLE) @(posedge clk);
        board.close_out();

        $display("Run: %0d indexes over %0d wheel settings, %0d colours compared.",
                 sent, PHASES + 1, board.checked);
        $display("Counts zero, one, small and full range; saturation and brightness at both ends.");
        if (board.errors == 0)
            $display("tb_hue_wheel_hsv_to_rgb_core: clean");
        else
            $display("tb_hue_wheel_hsv_to_rgb_core: errors");
        $finish;
    end

endmodule

[hue_wheel_hsv_to_rgb_core.f]
hdl/hwh_pkg.sv
hdl/hue_wheel_hsv_to_rgb_core.sv
hdl/hwh_checker.sv
tb/tb_hue_wheel_hsv_to_rgb_core.sv
